### sv/chr_tile_planar_decoder_top_assert.svh
// ----------------------------------------------------------------------------
// chr_tile_planar_decoder_top_assert.svh
// Assertion macros used by the tile decoder checker chr_tpd_chk.
// ----------------------------------------------------------------------------
`ifndef CHR_TILE_PLANAR_DECODER_TOP_ASSERT_SVH
`define CHR_TILE_PLANAR_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CHR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CHR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/chr_tpd_pkg.sv
// ----------------------------------------------------------------------------
// chr_tpd_pkg
// Beat types and fixed constants of the planar tile decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package chr_tpd_pkg;

  localparam int unsigned PLANE_BITS  = 64;  // one plane of an 8x8 tile
  localparam int unsigned PIX_CNT_W   = 6;   // 64 pixels per tile
  localparam int unsigned POS_W       = 4;   // 16 bytes per tile

  localparam logic [POS_W-1:0]     POS_LAST = 4'hF;
  localparam logic [PIX_CNT_W-1:0] PIX_LAST = 6'd63;

  typedef struct packed {
    logic [7:0] chr_byte;
    logic       restart;
  } in_t;

  typedef struct packed {
    logic [7:0] pixel_x;
    logic [6:0] pixel_y;
    logic [1:0] color_index;
    logic       last_of_tile;
  } out_t;

endpackage

### sv/chr_tile_planar_decoder_top.sv
// The first pixel of a tile is valid in the cycle after its 16th byte is taken; then one
// pixel per cycle follows while out_stall is low, 64 in all; the bit-serial plane shift registers set this pace.
// Bytes are taken one per cycle while a tile fills; a 16th byte waits until the
// previous tile's last pixel is taken.
// Reset (synchronous, rst_n low): byte position, tile count and emitter go idle.
// ----------------------------------------------------------------------------
// chr_tile_planar_decoder_top
// Buffers 2bpp planar tile bytes in two 64-bit plane shift registers and shifts
// out one pixel per cycle, with its position in a 256x128 image.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chr_tile_planar_decoder_top
  import chr_tpd_pkg::*;
#(
  parameter int unsigned TILES_PER_TABLE = 256
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int unsigned IDX_W = $clog2(TILES_PER_TABLE);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TILES_PER_TABLE - 1);

  // fill side
  logic [POS_W-1:0]      pos_r, pos_eff, pos_nxt;
  logic [PLANE_BITS-1:0] lo_fill_r, hi_fill_r;
  logic [IDX_W-1:0]      idx_r, idx_eff, idx_nxt;
  logic                  tbl_r, tbl_eff, tbl_nxt;
  logic                  full_r, full_eff, full_nxt;

  // emit side
  logic [PLANE_BITS-1:0] lo_q_r, hi_q_r;
  logic [PIX_CNT_W-1:0]  pix_r;
  logic                  busy_r;
  logic [IDX_W-1:0]      em_idx_r;
  logic                  em_tbl_r;

  logic in_acc, out_acc, tile_done, load, last_pix;

  assign last_pix  = (pix_r == PIX_LAST);
  assign out_acc   = busy_r && !out_stall;
  // a finishing byte needs the emitter free, or freeing this cycle
  assign in_stall  = busy_r && (pos_r == POS_LAST) && !(out_acc && last_pix);
  assign in_acc    = in_valid && !in_stall;

  // restart clears the tile count and byte position before this beat
  assign pos_eff   = in_data.restart ? '0 : pos_r;
  assign idx_eff   = in_data.restart ? '0 : idx_r;
  assign tbl_eff   = in_data.restart ? 1'b0 : tbl_r;
  assign full_eff  = in_data.restart ? 1'b0 : full_r;

  assign tile_done = in_acc && (pos_eff == POS_LAST);
  assign load      = tile_done && !full_eff;

  always_comb begin
    pos_nxt  = pos_eff + POS_W'(1);
    idx_nxt  = idx_eff;
    tbl_nxt  = tbl_eff;
    full_nxt = full_eff;
    if (load) begin
      if (idx_eff == IDX_LAST) begin
        idx_nxt = '0;
        if (tbl_eff) begin
          full_nxt = 1'b1;
        end else begin
          tbl_nxt = 1'b1;
        end
      end else begin
        idx_nxt = idx_eff + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      idx_r  <= '0;
      tbl_r  <= 1'b0;
      full_r <= 1'b0;
    end else if (in_acc) begin
      pos_r  <= pos_nxt;
      idx_r  <= idx_nxt;
      tbl_r  <= tbl_nxt;
      full_r <= full_nxt;
    end
  end

  // rows shift in at the bottom, so row 0's MSB ends at the top bit
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (!pos_eff[POS_W-1]) begin
        lo_fill_r <= {lo_fill_r[PLANE_BITS-9:0], in_data.chr_byte};
      end else begin
        hi_fill_r <= {hi_fill_r[PLANE_BITS-9:0], in_data.chr_byte};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pix_r  <= '0;
    end else if (load) begin
      busy_r   <= 1'b1;
      pix_r    <= '0;
      lo_q_r   <= lo_fill_r;
      hi_q_r   <= {hi_fill_r[PLANE_BITS-9:0], in_data.chr_byte};
      em_idx_r <= idx_eff;
      em_tbl_r <= tbl_eff;
    end else if (out_acc) begin
      // advance one pixel
      lo_q_r <= {lo_q_r[PLANE_BITS-2:0], 1'b0};
      hi_q_r <= {hi_q_r[PLANE_BITS-2:0], 1'b0};
      pix_r  <= pix_r + PIX_CNT_W'(1);
      if (last_pix) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign out_valid             = busy_r;
  assign out_data.pixel_x      = {em_tbl_r, em_idx_r[3:0], pix_r[2:0]};
  assign out_data.pixel_y      = 7'({em_idx_r >> 4, pix_r[5:3]});
  assign out_data.color_index  = {hi_q_r[PLANE_BITS-1], lo_q_r[PLANE_BITS-1]};
  assign out_data.last_of_tile = last_pix;

endmodule

### sv/chr_tpd_chk.sv
// ----------------------------------------------------------------------------
// chr_tpd_chk
// Port-level checks of the planar tile decoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "chr_tile_planar_decoder_top_assert.svh"

module chr_tpd_chk
  import chr_tpd_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_data,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  logic       in_wait, out_wait, out_take, mid_row, row_step, corner;
  logic [7:0] x_prev_r;
  logic [6:0] y_prev_r;

  assign in_wait  = in_valid && in_stall;
  assign out_wait = out_valid && out_stall;
  assign out_take = out_valid && !out_stall;
  assign mid_row  = out_take && (out_data.pixel_x[2:0] != 3'd7);
  assign row_step = (out_data.pixel_x == x_prev_r + 8'd1) && (out_data.pixel_y == y_prev_r);
  assign corner   = (out_data.pixel_x[2:0] == 3'd7) && (out_data.pixel_y[2:0] == 3'd7);

  // hold the previous beat's position for the row step check
  always_ff @(posedge clk) begin
    x_prev_r <= out_data.pixel_x;
    y_prev_r <= out_data.pixel_y;
  end

  `CHR_ASSERT_NEXT(a_in_hold, in_wait, in_valid && $stable(in_data), "stalled input beat changed")
  `CHR_ASSERT_NEXT(a_out_hold, out_wait, out_valid && $stable(out_data), "stalled beat changed")
  `CHR_ASSERT_NEXT(a_tile_no_gap, out_take && !out_data.last_of_tile, out_valid, "gap inside a tile")
  `CHR_ASSERT_NEXT(a_x_step, mid_row, row_step, "pixel step within a row broken")
  `CHR_ASSERT_SAME(a_last_corner, out_valid && out_data.last_of_tile, corner, "last pixel off corner")

endmodule

bind chr_tile_planar_decoder_top chr_tpd_chk u_chr_tpd_chk (.*);
